/* sv/packed_10bit_gray_unpacker_assert.svh */
// Assertion macros for the packed 10-bit gray unpacker.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef PACKED_10BIT_GRAY_UNPACKER_ASSERT_SVH
`define PACKED_10BIT_GRAY_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define P10GU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define P10GU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/p10gu_pkg.sv */
// Shared types and constants for the packed 10-bit gray unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none

package p10gu_pkg;

    localparam int WORD_W           = 32;
    localparam int FILL_W           = 2;
    localparam int SAMPLE_W         = 10;
    localparam int WIDE_W           = 16;
    localparam int SAMPLES_PER_WORD = 3;
    localparam int FRAME_W          = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int COUNT_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Number of samples a job carries: 1 to 3.
    localparam int JOB_CNT_W = 2;
    localparam logic [JOB_CNT_W-1:0] JOB_FULL = JOB_CNT_W'(SAMPLES_PER_WORD);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWAP_BYTES   = 2'd0,
        REG_FRAME_PIXELS = 2'd1
    } t_cfg_reg;

    // One word's worth of work, handed from front to back.
    typedef struct packed {
        logic [WORD_W-FILL_W-1:0] bits;   // word with fill bits dropped
        logic [JOB_CNT_W-1:0]     count;  // samples to emit
        logic                     fend;   // last sample closes the frame
    } t_job;

endpackage

`default_nettype wire

/* sv/p10gu_front.sv */
// Front end: config registers, word intake, byte swap and pixel counting.
// Depends on p10gu_pkg; feeds jobs into p10gu_queue.
`default_nettype none

module p10gu_front
    import p10gu_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAME_W-1:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [WORD_W-1:0]    i_packed_word,
    input  wire logic                 i_queue_full,
    output logic                      o_push,
    output t_job                      o_job
);

    localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    logic                  r_swap;
    logic [COUNT_BITS-1:0] r_left;
    logic [COUNT_BITS-1:0] n_left;
    logic [COUNT_BITS-1:0] load_val;
    logic [63:0]           cfg_wide;
    logic [WORD_W-1:0]     word;
    logic [JOB_CNT_W-1:0]  take;
    logic                  accept;
    logic                  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_stall     = i_queue_full;
    assign accept      = i_valid && !o_stall;

    // Saturate the frame size to what the counter can hold.
    assign cfg_wide = 64'(i_cfg_data);
    assign load_val = (cfg_wide > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                           : cfg_wide[COUNT_BITS-1:0];

    assign word = r_swap ? {i_packed_word[7:0], i_packed_word[15:8],
                            i_packed_word[23:16], i_packed_word[31:24]}
                         : i_packed_word;

    assign take = (r_left >= COUNT_BITS'(SAMPLES_PER_WORD)) ? JOB_FULL
                                                            : r_left[JOB_CNT_W-1:0];

    assign o_push      = accept && (r_left != '0);
    assign o_job.bits  = word[WORD_W-1:FILL_W];
    assign o_job.count = take;
    assign o_job.fend  = (r_left <= COUNT_BITS'(SAMPLES_PER_WORD));

    always_comb begin
        n_left = r_left;
        if (o_push) begin
            n_left = r_left - COUNT_BITS'(take);
        end
        if (cfg_we && (i_cfg_index == REG_FRAME_PIXELS)) begin
            n_left = load_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
            r_left <= COUNT_BITS'(1);
        end else begin
            r_left <= n_left;
            if (cfg_we && (i_cfg_index == REG_SWAP_BYTES)) begin
                r_swap <= i_cfg_data[0];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/p10gu_queue.sv */
// Short job queue between front and back.
// Depends on p10gu_pkg for the job type.
`default_nettype none

module p10gu_queue
    import p10gu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

/* sv/p10gu_back.sv */
// Back end: walks each job sample by sample into the output register.
// Depends on p10gu_pkg and the assertion macro header.
`default_nettype none
`include "packed_10bit_gray_unpacker_assert.svh"

module p10gu_back
    import p10gu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire t_job                i_job,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [WIDE_W-1:0]        o_sample,
    output logic                     o_last_of_word,
    output logic                     o_frame_end
);

    logic                 r_busy;
    t_job                 r_job;
    logic [JOB_CNT_W-1:0] r_idx;
    logic                 r_out_valid;
    logic [WIDE_W-1:0]    r_out_sample;
    logic                 r_out_last;
    logic                 r_out_fend;
    logic                 adv;
    logic                 last;
    logic [SAMPLE_W-1:0]  sel;

    assign adv   = r_busy && (!r_out_valid || !i_stall);
    assign last  = (r_idx == r_job.count - JOB_CNT_W'(1));
    assign o_pop = i_job_valid && (!r_busy || (adv && last));

    always_comb begin
        unique case (r_idx)
            2'd1:    sel = r_job.bits[2*SAMPLE_W-1:SAMPLE_W];
            2'd2:    sel = r_job.bits[3*SAMPLE_W-1:2*SAMPLE_W];
            default: sel = r_job.bits[SAMPLE_W-1:0];
        endcase
    end

    // Job tracking: reload straight from the queue so words run back to back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (adv && last) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_idx  <= r_idx + JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sample <= {sel, sel[SAMPLE_W-1:SAMPLE_W-(WIDE_W-SAMPLE_W)]};
            r_out_last   <= last;
            r_out_fend   <= last && r_job.fend;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_last_of_word = r_out_last;
    assign o_frame_end    = r_out_fend;

    `P10GU_ASSERT_NOW(a_fend_is_last, i_clk, i_rst_n, r_out_valid && r_out_fend, r_out_last, "frame end without last of word")
    `P10GU_ASSERT_NOW(a_job_nonzero, i_clk, i_rst_n, r_busy, r_job.count != '0 && r_idx < r_job.count, "sample index outside job")
    `P10GU_ASSERT_NOW(a_pop_when_free, i_clk, i_rst_n, o_pop && r_busy, adv && last, "job reloaded while samples remain")
    `P10GU_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, adv && last && !o_pop, !r_busy, "back end still busy after last sample")

endmodule

`default_nettype wire

/* sv/packed_10bit_gray_unpacker.sv */
// Packed 10-bit grayscale unpacker, top level. Each accepted 32-bit word
// holds three 10-bit samples above two fill bits; the word is optionally
// byte-reversed, the fill bits dropped, and samples taken from bit 2 upward
// (bits 11:2, 21:12, 31:22). Each sample leaves widened to 16 bits by bit
// replication, one sample per transfer, with last_of_word on the final sample
// of a word and frame_end on the final sample of the frame. A remaining-pixel
// counter, loaded from frame_pixels at reset (value 1) and on every write of
// that register, limits the frame; once it reaches zero, words are accepted
// and dropped until the count is written again. Register 0 is swap_bytes,
// register 1 is frame_pixels; other indexes are ignored. The config port is
// always ready. Rate: the output register moves one sample per cycle while
// i_stall is low, and the next job is taken as the last sample of a word
// leaves, so words run back to back. The first sample of a word passes
// through the job queue, the job register and the output register. The input
// stalls only when the job queue between the front and back halves is full.
// Depends on p10gu_pkg, p10gu_front, p10gu_queue and p10gu_back.
`default_nettype none

module packed_10bit_gray_unpacker
    import p10gu_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAME_W-1:0]   i_cfg_data,
    // word input
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [WORD_W-1:0]    i_packed_word,
    // sample output
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [WIDE_W-1:0]         o_sample,
    output logic                      o_last_of_word,
    output logic                      o_frame_end
);

    logic push;
    t_job push_job;
    logic queue_full;
    logic job_valid;
    t_job job;
    logic pop;

    // Front: take words, apply config, count pixels, hand off jobs.
    p10gu_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_packed_word (i_packed_word),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Queue: decouple intake from sample emission.
    p10gu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .o_valid (job_valid),
        .o_job   (job),
        .i_pop   (pop)
    );

    // Back: emit samples one per cycle through the output register while the output is not stalled.
    p10gu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (o_sample),
        .o_last_of_word (o_last_of_word),
        .o_frame_end    (o_frame_end)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for packed_10bit_gray_unpacker: directed and random words,
// predicted sample by sample in the bench and compared in order, with random idling.
// Depends on p10gu_pkg and the packed_10bit_gray_unpacker RTL.

module testbench;
    import p10gu_pkg::*;

    localparam int COUNT_W       = COUNT_BITS_DEF;
    // Indexes the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    // Cycles to let a dropped word drain out of the pipeline before a register write.
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 100;
    localparam int RANDOM_WORDS  = 104;

    typedef struct packed {
        logic [WIDE_W-1:0] sample;
        logic              last_of_word;
        logic              frame_end;
    } t_pixel;

    // DUT inputs start at known values; reset is held low from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [FRAME_W-1:0]   i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic [WORD_W-1:0]    i_packed_word = '0;
    logic                 i_stall       = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_stall;
    logic                 o_valid;
    logic [WIDE_W-1:0]    o_sample;
    logic                 o_last_of_word;
    logic                 o_frame_end;

    // Bench copy of the block's registers and frame counter, at their reset values.
    logic                 swap_on     = 1'b0;
    logic [COUNT_W-1:0]   pixels_left = COUNT_W'(1);

    t_pixel      pending_pixels[$];   // samples predicted but not yet seen
    int unsigned mismatches = 0;
    bit          quiet      = 1'b0;   // while set, neither side idles
    int unsigned rx_hold    = 0;

    packed_10bit_gray_unpacker uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_packed_word  (i_packed_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (o_sample),
        .o_last_of_word (o_last_of_word),
        .o_frame_end    (o_frame_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_wait();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // A frame size wider than the counter loads the counter's largest value.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [FRAME_W-1:0] n);
        longint unsigned top = (64'd1 << COUNT_W) - 1;
        if (longint'(n) > top)
            return COUNT_W'(top);
        return COUNT_W'(n);
    endfunction

    // Expected samples of one accepted word: optional byte reversal, drop the two
    // fill bits, then up to three 10-bit fields from the bottom, each widened to
    // 16 bits by repeating its top six bits below it. Nothing once the frame is done.
    function automatic void unpack_word(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0]   bits;
        logic [SAMPLE_W-1:0] s;
        t_pixel              px;
        bits = swap_on ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
        bits = bits >> FILL_W;
        for (int k = 0; k < SAMPLES_PER_WORD && pixels_left != 0; k++) begin
            s           = bits[SAMPLE_W-1:0];
            bits        = bits >> SAMPLE_W;
            pixels_left = pixels_left - 1'b1;
            px.sample       = {s, s[SAMPLE_W-1:SAMPLE_W-6]};
            px.frame_end    = (pixels_left == 0);
            px.last_of_word = px.frame_end || (k == SAMPLES_PER_WORD - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        // Print the first hundred, count all.
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t",
                     what, got, want, $time);
    endtask

    // Present one word after a random gap and hold it until the transfer.
    // With no gap, valid simply stays high for the next word.
    task automatic send_word(input logic [WORD_W-1:0] word);
        int unsigned gap;
        gap = pick_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_packed_word <= word;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        unpack_word(word);
    endtask

    // Drop valid, wait for every predicted sample, then let dropped words drain.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SWAP_BYTES: begin
                swap_on = data[0];
            end
            REG_FRAME_PIXELS: begin
                pixels_left = clamp_count(data);
            end
            default: begin
            end
        endcase
    endtask

    // Output side: check each transfer against the oldest prediction, then draw
    // how long to stall before taking the next sample.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("sample with none expected", o_sample, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_sample !== want.sample)
                    report_mismatch("sample", o_sample, want.sample);
                if (o_last_of_word !== want.last_of_word)
                    report_mismatch("last_of_word", o_last_of_word, want.last_of_word);
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
            end
            rx_hold = pick_wait();
        end else if (rx_hold != 0) begin
            rx_hold--;
        end
        i_stall <= (rx_hold != 0);
    end

    // Out of reset the frame is one pixel long: the first word gives one sample
    // that closes the frame, the second word is surplus.
    task automatic test_reset_state();
        send_word(32'hFFFF_FFFF);
        send_word(32'h1234_5678);
        wait_idle();
    endtask

    // All-zero, all-one, fill-only and one-field-only words unswapped, then two words swapped.
    task automatic test_field_extremes();
        write_reg(REG_SWAP_BYTES, 24'h00_0000);
        write_reg(REG_FRAME_PIXELS, 24'd27);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0003);
        send_word(32'hFFFF_FFFC);
        send_word(32'h0000_0FFC);
        send_word(32'h003F_F000);
        send_word(32'hFFC0_0000);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        // Upper data bits of the swap register carry no meaning.
        write_reg(REG_SWAP_BYTES, 24'hFF_FFFF);
        write_reg(REG_FRAME_PIXELS, 24'd6);
        send_word(32'h0102_0304);
        send_word(32'hFC00_0000);
    endtask

    // Surplus words, a partial last word, an empty frame, the largest frame,
    // and a restart of the count part way through a frame.
    task automatic test_frame_limits();
        write_reg(REG_SWAP_BYTES, 24'h00_0000);
        write_reg(REG_FRAME_PIXELS, 24'd4);
        repeat (3) send_word($urandom);
        write_reg(REG_FRAME_PIXELS, 24'd5);
        repeat (2) send_word($urandom);
        write_reg(REG_FRAME_PIXELS, 24'd0);
        repeat (2) send_word($urandom);
        write_reg(REG_FRAME_PIXELS, 24'hFF_FFFF);
        repeat (2) send_word($urandom);
        write_reg(REG_FRAME_PIXELS, 24'd9);
        send_word($urandom);
        write_reg(REG_FRAME_PIXELS, 24'd2);
        repeat (2) send_word($urandom);
    endtask

    // Writes to unused indexes must leave both registers alone; the data is
    // chosen so that a decode of the low index bit alone would show.
    task automatic test_spare_index();
        write_reg(REG_SWAP_BYTES, 24'h00_0001);
        write_reg(REG_FRAME_PIXELS, 24'd3);
        write_reg(REG_SPARE_2, 24'h00_0000);
        write_reg(REG_SPARE_3, 24'h00_0007);
        send_word(32'h89AB_CDEF);
    endtask

    // Frames of random size and swap with random content. Most run to their end,
    // some get surplus words, some are cut short and restarted by the next write.
    // A quarter of the frames run with no idling on either side.
    task automatic test_random_frames(input int unsigned word_goal);
        int unsigned sent = 0;
        int unsigned frame;
        int unsigned words;
        int unsigned roll;
        while (sent < word_goal) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                frame = 0;
            else if (roll == 1)
                frame = $urandom_range(1000, 24'hFF_FFFF);
            else
                frame = $urandom_range(1, 24);
            write_reg(REG_SWAP_BYTES, FRAME_W'($urandom));
            write_reg(REG_FRAME_PIXELS, FRAME_W'(frame));
            quiet = ($urandom_range(0, 3) == 0);
            words = (frame + 2) / 3;
            if (words > 8)
                words = 8;            // long frames: a few words only
            if (roll == 2)
                words = words / 2;    // cut short, restart on the next write
            else if ($urandom_range(0, 3) == 0)
                words += $urandom_range(1, 2);
            if (words == 0)
                words = 2;
            repeat (words) begin
                send_word($urandom);
                sent++;
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_field_extremes();
        test_frame_limits();
        test_spare_index();
        test_random_frames(RANDOM_WORDS);
        // Wait out the last samples, plus a margin to catch any extra ones.
        wait_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
